### design/kvst_pkg.sv
// Shared types and constants for the key/value slot table.
// Used by kvst_store, kvst_ctrl, key_value_slot_table and kvst_checker.
package kvst_pkg;

   localparam int SLOTS    = 64;
   localparam int KEY_BITS = 32;
   localparam int SLOT_W   = $clog2(SLOTS);

   // request kind codes
   localparam logic [1:0] KIND_SET    = 2'd0;
   localparam logic [1:0] KIND_GET    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_HIT  = 2'd0;
   localparam logic [1:0] STATUS_NEW  = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // read port request and registered read data of the slot store
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] idx;
   } rd_req_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   idx;
      logic                used;
      logic [KEY_BITS-1:0] key;
      logic [31:0]         value;
   } rd_data_type;

   typedef struct packed {
      logic                key_we;
      logic                val_we;
      logic                used_we;
      logic                used_val;
      logic [SLOT_W-1:0]   idx;
      logic [KEY_BITS-1:0] key;
      logic [31:0]         value;
   } wr_type;

endpackage

### design/kvst_store.sv
// Slot storage: key and value memories with registered read, plus occupancy bits.
// Depends on kvst_pkg.
module kvst_store (
   input  logic                 clock,
   input  logic                 reset,
   input  kvst_pkg::rd_req_type rd_req,
   output kvst_pkg::rd_data_type rd_data,
   input  kvst_pkg::wr_type     wr
);
   import kvst_pkg::*;

   logic [KEY_BITS-1:0] key_mem [SLOTS];
   logic [31:0]         val_mem [SLOTS];
   logic [SLOTS-1:0]    used_ff;
   rd_data_type         rd_ff;

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem[wr.idx] <= wr.key;
      end
      if (wr.val_we) begin
         val_mem[wr.idx] <= wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr.used_we) begin
         used_ff[wr.idx] <= wr.used_val;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff.idx   <= rd_req.idx;
      rd_ff.used  <= used_ff[rd_req.idx];
      rd_ff.key   <= key_mem[rd_req.idx];
      rd_ff.value <= val_mem[rd_req.idx];
      if (reset) begin
         rd_ff.valid <= 1'b0;
      end else begin
         rd_ff.valid <= rd_req.en;
      end
   end

   assign rd_data = rd_ff;

endmodule

### design/kvst_ctrl.sv
// Scan sequencer with the shared key comparator, commit decision and response register.
// Depends on kvst_pkg; drives the read and write ports of kvst_store.
module kvst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kvst_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kvst_pkg::rsp_type     rsp_payload,
   output kvst_pkg::rd_req_type  rd_req,
   input  kvst_pkg::rd_data_type rd_data,
   output kvst_pkg::wr_type      wr
);
   import kvst_pkg::*;

   state_type           state_ff, state_in;
   logic [1:0]          kind_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [31:0]         value_ff;
   logic [SLOT_W-1:0]   addr_ff;
   logic                hit_found_ff;
   logic [SLOT_W-1:0]   hit_idx_ff;
   logic [31:0]         hit_val_ff;
   logic                free_found_ff;
   logic [SLOT_W-1:0]   free_idx_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   wr_type              wr_plan;
   logic                accept;
   logic                commit_go;
   logic                last_addr;
   logic                cmp_hit;
   logic                cmp_free;

   assign accept    = req_valid && req_ready;
   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);
   assign last_addr = (addr_ff == SLOT_W'(SLOTS - 1));

   // shared comparator: one slot per cycle, first match and first free slot win
   assign cmp_hit  = rd_data.valid && rd_data.used && (rd_data.key == key_ff) && !hit_found_ff;
   assign cmp_free = rd_data.valid && !rd_data.used && !free_found_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // decide the store update and the response from the scan result
   always_comb begin
      wr_plan        = '0;
      wr_plan.idx    = hit_idx_ff;
      wr_plan.key    = key_ff;
      wr_plan.value  = value_ff;
      rsp_in         = '0;
      rsp_in.status  = STATUS_MISS;
      case (kind_ff)
         KIND_SET: begin
            if (hit_found_ff) begin
               wr_plan.val_we = 1'b1;
               rsp_in.status  = STATUS_HIT;
            end else if (free_found_ff) begin
               wr_plan.idx      = free_idx_ff;
               wr_plan.key_we   = 1'b1;
               wr_plan.val_we   = 1'b1;
               wr_plan.used_we  = 1'b1;
               wr_plan.used_val = 1'b1;
               rsp_in.status    = STATUS_NEW;
            end else begin
               rsp_in.status = STATUS_FULL;
            end
         end
         KIND_GET: begin
            if (hit_found_ff) begin
               rsp_in.status     = STATUS_HIT;
               rsp_in.read_value = hit_val_ff;
            end
         end
         KIND_REMOVE: begin
            if (hit_found_ff) begin
               wr_plan.used_we = 1'b1;
               rsp_in.status   = STATUS_HIT;
            end
         end
         default: begin
            rsp_in.status = STATUS_MISS;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      rd_req.en  = 1'b0;
      rd_req.idx = addr_ff;
      wr         = wr_plan;
      wr.key_we  = 1'b0;
      wr.val_we  = 1'b0;
      wr.used_we = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            rd_req.en = 1'b1;
         end
         ST_DRAIN: begin
            rd_req.en = 1'b0;
         end
         ST_COMMIT: begin
            wr.key_we  = wr_plan.key_we && commit_go;
            wr.val_we  = wr_plan.val_we && commit_go;
            wr.used_we = wr_plan.used_we && commit_go;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_payload.kind;
         key_ff   <= req_payload.key[KEY_BITS-1:0];
         value_ff <= req_payload.value;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         addr_ff <= addr_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (accept) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmp_hit) begin
            hit_found_ff <= 1'b1;
         end
         if (cmp_free) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_hit) begin
         hit_idx_ff <= rd_data.idx;
         hit_val_ff <= rd_data.value;
      end
      if (cmp_free) begin
         free_idx_ff <= rd_data.idx;
      end
   end

   // hold the response until taken; the next request may start meanwhile
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### design/key_value_slot_table.sv
// Top level of the key/value slot table.
// Depends on kvst_pkg, kvst_store and kvst_ctrl.
//
// Usage:
//   req_valid/req_ready/req_payload carry one transaction: kind (set, get,
//   remove), key and value. rsp_valid/rsp_ready/rsp_payload return exactly
//   one transaction per request: status (hit, inserted, miss, full) and
//   read_value (stored value on a get hit, otherwise zero).
//   Each request scans all SLOTS slots, one slot per cycle through a single
//   key comparator fed by the registered read port of the slot memories,
//   then compares the last slot in the drain step and writes in the commit
//   step. req_ready stays low from accept through the commit and is high
//   again the cycle after the commit, so a new request is taken only once
//   the last one has committed. The response sits in an output register;
//   a new request is accepted while it waits. If the receiver still stalls
//   when the next commit is due, the block holds in the commit step until
//   rsp_ready frees the register. Reset clears the occupancy bits, the
//   sequencer and rsp_valid at once; key and value memories are not
//   cleared and need no clearing pass.
module key_value_slot_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kvst_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kvst_pkg::rsp_type rsp_payload
);
   import kvst_pkg::*;

   rd_req_type  rd_req;
   rd_data_type rd_data;
   wr_type      wr;

   kvst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .rd_req      (rd_req),
      .rd_data     (rd_data),
      .wr          (wr)
   );

   kvst_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .rd_data (rd_data),
      .wr      (wr)
   );

endmodule

### design/kvst_checker.sv
// Port-level checks for key_value_slot_table, attached by bind.
// Depends on kvst_pkg.
module kvst_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input kvst_pkg::rsp_type rsp_payload
);
   import kvst_pkg::*;

   // busy for the whole scan and commit after a transaction is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready [*(SLOTS + 2)])
      else $error("request accepted during slot scan");

   // read_value is zero unless the status is hit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STATUS_HIT) |-> (rsp_payload.read_value == '0))
      else $error("nonzero read_value without hit");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

   // no response right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind key_value_slot_table kvst_checker u_kvst_checker (.*);
